// ===== hw/rtl/pis_pkg.sv =====
// Package for the permutation inverse block: sizes, opcodes and control structs.
// No dependencies.
package pis_pkg;
  localparam int unsigned MaxElements = 1024;
  localparam int unsigned CfgWidth = 11;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_INVERSE = 2'd2,
    OP_FORWARD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_BUILD = 2'd0,
    KIND_INVERSE = 2'd1,
    KIND_FORWARD = 2'd2
  } kind_t;

  localparam logic CFG_LENGTH = 1'b0;
  localparam logic CFG_SPACING = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted item
    logic rd_perm;     // read perm at cur
    logic rd_short;    // read shortcut store at cur
    logic rd_vis;      // read visited flag at scan
    logic wr_perm;     // write element
    logic clr;         // clear one flag entry at scan
    logic scan_inc;    // advance scan index
    logic scan_clr;    // return scan index to zero
    logic bstart;      // start a build walk at scan
    logic bstep;       // take one build step
    logic bclose;      // close build walk
    logic qstart;      // start inverse walk at key
    logic qstep;       // take one inverse step
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;    // scan index at the last table entry
    logic scan_done;   // scan index at or past the last active index
    logic scan_vis;    // visited flag at scan
    logic hit;         // perm at cur equals target
    logic bad;         // out of range or over bound
  } stat_t;
endpackage

// ===== hw/rtl/pis_if.sv =====
// Valid/ready channel interface carrying a payload of configurable type.
// Depends on nothing.
interface pis_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/permutation_inverse_shortcuts.sv =====
// Top level: permutation store with forward and inverse lookup via shortcuts.
// Build: clears the flags of every table entry, then scans each index and walks each unvisited cycle.
// Inverse query: reads and steps along the cycle, taking at most one shortcut jump.
// Forward query: reads the element store once; write: stores the item. One item at a time.
// Reset (rst, synchronous) sets length 1024 and spacing 16; shortcut bits read as clear
// until the first build has cleared the flag stores.
module permutation_inverse_shortcuts #(
  parameter int unsigned MAX_ELEMENTS = pis_pkg::MaxElements
) (
  input logic clk,
  input logic rst,
  pis_if.sink in_ch,
  pis_if.source out_ch,
  input logic cfg_we,
  input logic cfg_index,
  input logic [pis_pkg::CfgWidth-1:0] cfg_data
);
  import pis_pkg::*;
  logic [10:0] len_cfg, spc_cfg;
  cmd_t cmd;
  stat_t stat;
  logic [9:0] rd_value;
  logic [9:0] perm_value;
  logic bad_any, pos_ok;
  logic [1:0] op_q;
  logic [1:0] k; logic [9:0] v; logic f;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg <= 11'd1024; spc_cfg <= 11'd16;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LENGTH) len_cfg <= cfg_data;
      else if (cfg_index == CFG_SPACING) spc_cfg <= cfg_data;
    end
  end

  logic [10:0] nact;
  assign nact = (len_cfg == '0) ? 11'd1 :
                (32'(len_cfg) > 32'(MAX_ELEMENTS)) ? 11'(MAX_ELEMENTS) : len_cfg;
  assign pos_ok = {1'b0, in_ch.payload.position} < nact;

  pis_datapath #(.MAX_EL(MAX_ELEMENTS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_op(in_ch.payload.opcode), .in_pos(in_ch.payload.position),
    .in_val(in_ch.payload.element_value),
    .len_cfg, .spc_cfg, .rd_value, .perm_value, .bad_any, .op_q
  );

  pis_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.payload.opcode), .pos_ok,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .stat, .op_q, .bad_any, .rd_value, .fwd_value(perm_value),
    .res_kind(k), .res_value(v), .res_flag(f)
  );

  assign out_ch.payload.result_kind = kind_t'(k);
  assign out_ch.payload.result_value = v;
  assign out_ch.payload.not_permutation = f;

  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_build_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.payload.result_kind == KIND_BUILD |->
    out_ch.payload.result_value == '0) else $error("build value nonzero");
endmodule

// ===== hw/rtl/pis_datapath.sv =====
// Datapath: element, flag and shortcut stores, walk registers and checks.
// Depends on pis_pkg.
module pis_datapath #(
  parameter int unsigned MAX_EL = pis_pkg::MaxElements,
  parameter int unsigned AW = $clog2(MAX_EL)
) (
  input  logic clk,
  input  logic rst,
  input  pis_pkg::cmd_t cmd,
  output pis_pkg::stat_t stat,
  input  logic [1:0] in_op,
  input  logic [9:0] in_pos,
  input  logic [9:0] in_val,
  input  logic [10:0] len_cfg,
  input  logic [10:0] spc_cfg,
  output logic [9:0] rd_value,
  output logic [9:0] perm_value,
  output logic bad_any,
  output logic [1:0] op_q
);
  import pis_pkg::*;
  localparam int unsigned CW = AW + 2;

  logic [9:0] perm_mem [MAX_EL];
  logic [9:0] tgt_mem [MAX_EL];
  logic vis_mem [MAX_EL];
  logic sv_mem [MAX_EL];
  logic [9:0] perm_rd, tgt_rd;
  logic sv_rd, vis_rd, built, plant;
  logic [AW-1:0] cur, key, start, mark, scan;
  logic [9:0] pos_q;
  logic [9:0] in_val_q;
  logic [CW-1:0] steps, run, n, spc;
  logic jumped, planted;

  // Active length clamped to 1 .. MAX_EL.
  always_comb begin
    if (len_cfg == '0) n = CW'(1);
    else if (CW'(len_cfg) > CW'(MAX_EL)) n = CW'(MAX_EL);
    else n = CW'(len_cfg);
    spc = CW'(spc_cfg);
  end

  assign plant = (run + CW'(1) == spc);

  always_ff @(posedge clk) begin
    if (cmd.rd_perm) perm_rd <= perm_mem[cur];
    if (cmd.rd_short) tgt_rd <= tgt_mem[cur];
    if (cmd.wr_perm && ({22'd0, pos_q} < 32'(MAX_EL)))
      perm_mem[pos_q[AW-1:0]] <= in_val_q;
    if (cmd.bstep && run + CW'(1) == spc) tgt_mem[cur] <= 10'(mark);
    if (cmd.bclose && planted) tgt_mem[start] <= 10'(mark);
  end

  logic [CW-1:0] nxt_ext, tgt_ext;
  assign nxt_ext = CW'(perm_rd);
  assign tgt_ext = CW'(tgt_rd);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= in_op;
      pos_q <= in_pos;
      in_val_q <= in_val;
      cur <= AW'(in_pos);
      key <= AW'(in_pos);
      scan <= '0;
    end
    if (cmd.scan_inc) scan <= scan + AW'(1);
    if (cmd.scan_clr) scan <= '0;
    if (cmd.bstart) begin
      cur <= scan; start <= scan; mark <= scan;
      run <= '0; steps <= '0; planted <= 1'b0;
    end
    if (cmd.bstep) begin
      if (run + CW'(1) == spc) begin
        run <= '0; planted <= 1'b1; mark <= cur;
      end else run <= run + CW'(1);
      steps <= steps + CW'(1);
      cur <= AW'(perm_rd);
    end
    if (cmd.qstart) begin
      steps <= '0; jumped <= 1'b0;
    end
    if (cmd.qstep) begin
      steps <= steps + CW'(1);
      if (!jumped && sv_rd) begin
        jumped <= 1'b1; cur <= AW'(tgt_rd);
      end else cur <= AW'(perm_rd);
    end
  end

  // Flag stores: every entry is cleared one a cycle at the start of a build.
  always_ff @(posedge clk) begin
    if (cmd.rd_vis) vis_rd <= vis_mem[scan];
    if (cmd.clr) vis_mem[scan] <= 1'b0;
    else if (cmd.bstep || cmd.bclose) vis_mem[cur] <= 1'b1;
  end

  // Until the first clearing pass has run, shortcut bits read as clear.
  always_ff @(posedge clk) begin
    if (cmd.rd_short) sv_rd <= built & sv_mem[cur];
    if (cmd.clr) sv_mem[scan] <= 1'b0;
    else if (cmd.bstep && plant) sv_mem[cur] <= 1'b1;
    else if (cmd.bclose && planted) sv_mem[start] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) built <= 1'b0;
    else if (cmd.scan_clr) built <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) bad_any <= 1'b0;
    else if (cmd.load) bad_any <= 1'b0;
    else if ((cmd.bstep || cmd.qstep) && stat.bad) bad_any <= 1'b1;
  end

  logic qjump;
  assign qjump = !jumped && sv_rd;
  always_comb begin
    stat.clr_done = (scan == AW'(MAX_EL - 1));
    stat.scan_done = (CW'(scan) + CW'(1) >= n) ;
    stat.scan_vis = vis_rd;
    if (op_q == OP_BUILD) begin
      stat.hit = perm_rd == 10'(start);
      stat.bad = nxt_ext >= n || steps + CW'(1) > n;
    end else begin
      stat.hit = perm_rd == 10'(key);
      stat.bad = (qjump ? tgt_ext : nxt_ext) >= n ||
                 (CW+1)'(steps) + (CW+1)'(1) > ((CW+1)'(n) << 1) + (CW+1)'(1);
    end
  end

  assign rd_value = 10'(cur);
  assign perm_value = perm_rd;
endmodule

// ===== hw/rtl/pis_ctrl.sv =====
// Controller state machine sequencing writes, builds and queries.
// Depends on pis_pkg.
module pis_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_op,
  input  logic pos_ok,
  output logic out_valid,
  input  logic out_ready,
  output pis_pkg::cmd_t cmd,
  input  pis_pkg::stat_t stat,
  input  logic [1:0] op_q,
  input  logic bad_any,
  input  logic [9:0] rd_value,
  input  logic [9:0] fwd_value,
  output logic [1:0] res_kind,
  output logic [9:0] res_value,
  output logic res_flag
);
  import pis_pkg::*;
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_WRITE = 10'b0000000010, S_CLR = 10'b0000000100,
    S_SREAD = 10'b0000001000, S_SCAN = 10'b0000010000, S_BREAD = 10'b0000100000,
    S_BSTEP = 10'b0001000000, S_QREAD = 10'b0010000000, S_QSTEP = 10'b0100000000,
    S_OUT = 10'b1000000000
  } state_t;
  state_t state, state_next;
  logic posok_q;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        case (opcode_t'(in_op))
          OP_WRITE: state_next = S_WRITE;
          OP_BUILD: state_next = S_CLR;
          OP_INVERSE: begin cmd.qstart = 1'b1; state_next = S_QREAD; end
          default: state_next = S_QREAD;
        endcase
      end
      S_WRITE: begin cmd.wr_perm = 1'b1; state_next = S_IDLE; end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          cmd.scan_clr = 1'b1; state_next = S_SREAD;
        end else cmd.scan_inc = 1'b1;
      end
      S_SREAD: begin cmd.rd_vis = 1'b1; state_next = S_SCAN; end
      S_SCAN: begin
        if (stat.scan_vis) begin
          if (stat.scan_done) state_next = S_OUT;
          else begin cmd.scan_inc = 1'b1; state_next = S_SREAD; end
        end else begin
          cmd.bstart = 1'b1; state_next = S_BREAD;
        end
      end
      S_BREAD: begin cmd.rd_perm = 1'b1; state_next = S_BSTEP; end
      S_BSTEP: begin
        if (stat.hit) begin
          cmd.bclose = 1'b1;
          state_next = stat.scan_done ? S_OUT : S_SREAD;
          cmd.scan_inc = !stat.scan_done;
        end else begin
          cmd.bstep = 1'b1;
          if (stat.bad) begin
            state_next = stat.scan_done ? S_OUT : S_SREAD;
            cmd.scan_inc = !stat.scan_done;
          end else state_next = S_BREAD;
        end
      end
      S_QREAD: begin
        if (!posok_q || op_q == OP_FORWARD) begin
          cmd.rd_perm = 1'b1; state_next = S_OUT;
          if (op_q == OP_INVERSE && !posok_q) state_next = S_OUT;
        end else begin
          cmd.rd_perm = 1'b1; cmd.rd_short = 1'b1; state_next = S_QSTEP;
        end
      end
      S_QSTEP: begin
        if (stat.hit) state_next = S_OUT;
        else begin
          cmd.qstep = 1'b1;
          state_next = stat.bad ? S_OUT : S_QREAD;
        end
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; posok_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) posok_q <= pos_ok;
    end
  end

  always_comb begin
    res_kind = KIND_BUILD; res_value = '0; res_flag = 1'b0;
    case (opcode_t'(op_q))
      OP_BUILD: res_flag = bad_any;
      OP_FORWARD: begin
        res_kind = KIND_FORWARD;
        res_flag = !posok_q;
        res_value = posok_q ? fwd_value : '0;
      end
      OP_INVERSE: begin
        res_kind = KIND_INVERSE;
        res_flag = !posok_q || bad_any;
        res_value = res_flag ? '0 : rd_value;
      end
      default: res_kind = KIND_BUILD;
    endcase
  end
endmodule

// ===== sim/tb_top.sv =====
// Testbench for permutation_inverse_shortcuts: it drives write, build, inverse and forward
// items and checks every result against a predictor of the block kept here.
// Depends on pis_pkg, pis_if and the block itself.
`timescale 1ns / 100ps

module tb_top;
  import pis_pkg::*;

  typedef struct packed {
    opcode_t opcode;
    logic [9:0] position;
    logic [9:0] element_value;
  } in_item_t;

  typedef struct packed {
    kind_t result_kind;
    logic [9:0] result_value;
    logic not_permutation;
  } out_item_t;

  localparam int WatchdogLimit = 40000;
  localparam int SettleCycles = 24;
  localparam int RandomItems = 380;
  localparam int HoldOffCycles = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_LENGTH;
  logic [CfgWidth-1:0] cfg_data = '0;

  pis_if #(.T(in_item_t)) in_if (clk);
  pis_if #(.T(out_item_t)) out_if (clk);

  permutation_inverse_shortcuts DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_if.sink),
    .out_ch(out_if.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  logic [CfgWidth-1:0] len_reg = 11'd1024;
  logic [CfgWidth-1:0] spacing_reg = 11'd16;
  logic [9:0] perm_mem [MaxElements];
  bit seen_mem [MaxElements];
  bit short_ok [MaxElements];
  logic [9:0] short_to [MaxElements];

  out_item_t pending_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int builds_sent = 0;
  int broken_seen = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_count = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
  end

  function automatic int live_len();
    int n;
    n = len_reg;
    if (n < 1) n = 1;
    if (n > MaxElements) n = MaxElements;
    return n;
  endfunction

  function automatic bit build_shortcuts();
    int n, pos, run, mark, steps, planted, nxt, s;
    bit bad, closed;
    n = live_len();
    bad = 0;
    for (int i = 0; i < MaxElements; i++) begin
      seen_mem[i] = 0;
      short_ok[i] = 0;
    end
    for (s = 0; s < n; s++) begin
      if (seen_mem[s]) continue;
      pos = s; run = 0; mark = s; steps = 0; planted = 0; closed = 1;
      while (perm_mem[pos] != s) begin
        nxt = perm_mem[pos];
        seen_mem[pos] = 1;
        run++;
        if (run == spacing_reg) begin
          run = 0;
          planted++;
          short_ok[pos] = 1;
          short_to[pos] = mark[9:0];
          mark = pos;
        end
        steps++;
        if (nxt >= n || steps > n) begin
          closed = 0;
          break;
        end
        pos = nxt;
      end
      if (!closed) begin
        bad = 1;
        continue;
      end
      seen_mem[pos] = 1;
      if (planted > 0) begin
        short_ok[s] = 1;
        short_to[s] = mark[9:0];
      end
    end
    return bad;
  endfunction

  // Returns -1 when the walk breaks.
  function automatic int find_preimage(int key);
    int n, pos, steps, nxt;
    bit jumped;
    n = live_len();
    pos = key; steps = 0; jumped = 0;
    while (perm_mem[pos] != key) begin
      if (!jumped && short_ok[pos]) begin
        jumped = 1;
        nxt = short_to[pos];
      end else begin
        nxt = perm_mem[pos];
      end
      steps++;
      if (nxt >= n || steps > 2 * n + 1) return -1;
      pos = nxt;
    end
    return pos;
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t r;
    int n, ans;
    n = live_len();
    r = '0;
    case (it.opcode)
      OP_WRITE: begin
        perm_mem[it.position] = it.element_value;
        return;
      end
      OP_BUILD: begin
        r.result_kind = KIND_BUILD;
        r.not_permutation = build_shortcuts();
      end
      OP_INVERSE: begin
        r.result_kind = KIND_INVERSE;
        ans = (it.position < n) ? find_preimage(it.position) : -1;
        if (ans < 0) r.not_permutation = 1'b1;
        else r.result_value = ans[9:0];
      end
      default: begin
        r.result_kind = KIND_FORWARD;
        if (it.position < n) r.result_value = perm_mem[it.position];
        else r.not_permutation = 1'b1;
      end
    endcase
    pending_results.push_back(r);
  endfunction

  // Offers one item; the caller stands at a rising edge.
  task automatic send_item(opcode_t op, int pos, int val);
    in_item_t it;
    it.opcode = op;
    it.position = pos[9:0];
    it.element_value = val[9:0];
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    predict_item(it);
    items_sent++;
    if (op == OP_BUILD) builds_sent++;
    if (!calm && $urandom_range(0, 99) < 24) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CfgWidth-1:0];
    @(posedge clk);
    if (idx == CFG_LENGTH) len_reg = val[CfgWidth-1:0];
    else spacing_reg = val[CfgWidth-1:0];
  endtask

  task automatic configure(int len, int spacing);
    drain();
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_SPACING, spacing);
    cfg_we <= 1'b0;
  endtask

  task automatic load_permutation(int n);
    int order [];
    int j, t;
    order = new[n];
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < n; i++) send_item(OP_WRITE, i, order[i]);
  endtask

  // Every entry is written once here, so no later walk meets an unwritten one.
  task automatic test_full_table();
    load_permutation(MaxElements);
    send_item(OP_BUILD, 0, 0);
    for (int i = 0; i < 6; i++) send_item(OP_INVERSE, $urandom_range(0, 1023), 0);
    send_item(OP_INVERSE, 1023, 0);
    send_item(OP_FORWARD, 1023, 0);
  endtask

  task automatic test_directed();
    configure(8, 2);
    for (int i = 0; i < 8; i++) send_item(OP_WRITE, i, (i + 1) % 8);
    send_item(OP_BUILD, 0, 0);
    send_item(OP_INVERSE, 0, 0);
    send_item(OP_INVERSE, 5, 0);
    send_item(OP_INVERSE, 1023, 0);
    send_item(OP_FORWARD, 8, 0);
    send_item(OP_WRITE, 900, 1023);
    // A value beyond the length breaks the cycle during the build.
    send_item(OP_WRITE, 3, 1023);
    send_item(OP_BUILD, 0, 0);
    send_item(OP_INVERSE, 2, 0);
    send_item(OP_FORWARD, 3, 0);
    configure(0, 0);
    send_item(OP_BUILD, 0, 0);
    send_item(OP_INVERSE, 0, 0);
    configure(2047, 1024);
    send_item(OP_FORWARD, 1023, 0);
    configure(8, 2047);
    send_item(OP_INVERSE, 4, 0);
    configure(1, 1);
    send_item(OP_BUILD, 0, 0);
  endtask

  task automatic random_phase(int n, int spacing);
    int queries, r;
    configure(n, spacing);
    load_permutation(n);
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 3))
        send_item(OP_WRITE, $urandom_range(0, n - 1), $urandom_range(0, 1023));
    end
    send_item(OP_BUILD, 0, 0);
    queries = $urandom_range(10, 30);
    for (int q = 0; q < queries; q++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_item(OP_INVERSE, $urandom_range(0, n - 1), $urandom_range(0, 1023));
      else if (r < 85) send_item(OP_FORWARD, $urandom_range(0, n - 1), $urandom_range(0, 1023));
      else if (r < 90) send_item(opcode_t'($urandom_range(2, 3)), $urandom_range(0, 1023), 0);
      else if (r < 96) send_item(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else send_item(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  task automatic test_random();
    int start, n, spacing;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      // A calm stretch in the middle of the run, with no idling on either channel.
      calm = (items_sent - start > 100 && items_sent - start < 300);
      if ($urandom_range(0, 99) < 10) n = $urandom_range(49, 200);
      else n = $urandom_range(2, 48);
      case ($urandom_range(0, 5))
        0: spacing = 0;
        1: spacing = 1;
        2: spacing = 1024;
        default: spacing = $urandom_range(1, n);
      endcase
      random_phase(n, spacing);
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    configure(16, 3);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 40; i++) send_item(OP_FORWARD, $urandom_range(0, 15), 0);
    send_item(OP_BUILD, 0, 0);
    for (int i = 0; i < 20; i++) send_item(OP_INVERSE, $urandom_range(0, 15), 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_left <= HoldOffCycles;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      results_seen++;
      if (got.not_permutation) broken_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind || got.result_value !== want.result_value
            || got.not_permutation !== want.not_permutation) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_table();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("Sent %0d items, %0d of them builds; checked %0d results, %0d flagged broken.",
             items_sent, builds_sent, results_seen, broken_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
